// ----- hw/rtl/jas_pkg.sv -----
// Shared types, constants and request codes for the journaled access set.
`default_nettype none
package jas_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int REQ_W   = 3;
	localparam int SNAP_W  = 7;
	localparam int DEPTH_W = 7;

	localparam logic [REQ_W-1:0] REQ_TOUCH_ADDR = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TOUCH_SLOT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY_ADDR = 3'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY_SLOT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REVERT     = 3'd4;

	typedef struct packed {
		logic        is_slot;
		logic [31:0] addr_high;
		logic [63:0] addr_mid;
		logic [63:0] addr_low;
		logic [63:0] slot_w3;
		logic [63:0] slot_w2;
		logic [63:0] slot_w1;
		logic [63:0] slot_w0;
	} key_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_idx;
		logic [CNT_W-1:0] fill;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_RES
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/jas_req_if.sv -----
// Request channel: valid/ready handshake with the lookup key and revert depth.
`default_nettype none
interface jas_req_if;
	logic                           valid;
	logic                           ready;
	logic [jas_pkg::REQ_W-1:0]      req_type;
	logic [31:0]                    addr_high;
	logic [63:0]                    addr_mid;
	logic [63:0]                    addr_low;
	logic [63:0]                    slot_w3;
	logic [63:0]                    slot_w2;
	logic [63:0]                    slot_w1;
	logic [63:0]                    slot_w0;
	logic [jas_pkg::SNAP_W-1:0]     snapshot_id;

	modport source (
		output valid, req_type, addr_high, addr_mid, addr_low,
		output slot_w3, slot_w2, slot_w1, slot_w0, snapshot_id,
		input  ready
	);
	modport sink (
		input  valid, req_type, addr_high, addr_mid, addr_low,
		input  slot_w3, slot_w2, slot_w1, slot_w0, snapshot_id,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/jas_res_if.sv -----
// Result channel: valid/ready handshake with warmth, depth and full flag.
`default_nettype none
interface jas_res_if;
	logic                         valid;
	logic                         ready;
	logic                         was_warm;
	logic [jas_pkg::DEPTH_W-1:0]  depth_now;
	logic                         full_res;

	modport source (
		output valid, was_warm, depth_now, full_res,
		input  ready
	);
	modport sink (
		input  valid, was_warm, depth_now, full_res,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/jas_cell.sv -----
// One storage cell: holds an entry, compares it with the incoming key, extends the hit chain.
`default_nettype none
module jas_cell (
	input  wire logic                      clk,
	input  wire logic [jas_pkg::IDX_W-1:0] idx,
	input  wire logic                      cmp_en,
	input  wire jas_pkg::key_t             cmp_key,
	input  wire jas_pkg::key_t             wr_key,
	input  wire jas_pkg::cell_ctl_t        ctl,
	input  wire logic                      hit_in,
	output logic                           hit_out
);

	jas_pkg::key_t entry_q;
	logic          match_q;
	logic          match_d;
	logic          occupied;

	// Compare the key: slot words count only for slot entries
	always_comb begin
		match_d = (entry_q.is_slot == cmp_key.is_slot) &&
		          (entry_q.addr_high == cmp_key.addr_high) &&
		          (entry_q.addr_mid == cmp_key.addr_mid) &&
		          (entry_q.addr_low == cmp_key.addr_low);
		if (cmp_key.is_slot) begin
			match_d = match_d &&
			          (entry_q.slot_w3 == cmp_key.slot_w3) &&
			          (entry_q.slot_w2 == cmp_key.slot_w2) &&
			          (entry_q.slot_w1 == cmp_key.slot_w1) &&
			          (entry_q.slot_w0 == cmp_key.slot_w0);
		end
	end

	// Capture the compare as the item is taken
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= match_d;
		end
	end

	// Store a pushed entry when this cell is the top of the stack
	always_ff @(posedge clk) begin
		if (ctl.we && (ctl.wr_idx == idx)) begin
			entry_q <= wr_key;
		end
	end

	// Only cells below the fill count take part
	assign occupied = ({1'b0, idx} < (jas_pkg::IDX_W + 1)'(ctl.fill));
	assign hit_out  = hit_in | (match_q & occupied);

endmodule
`default_nettype wire

// ----- hw/rtl/jas_ctrl.sv -----
// Sequencer: fill count, request decode, result register and cell write control.
`default_nettype none
module jas_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       acc,
	input  wire logic [jas_pkg::REQ_W-1:0]  req_type,
	input  wire logic [jas_pkg::SNAP_W-1:0] snapshot_id,
	input  wire logic                       hit,
	input  wire logic                       out_ready,
	output logic                            in_ready,
	output jas_pkg::cell_ctl_t              ctl,
	output logic                            out_valid,
	output logic                            out_warm,
	output logic [jas_pkg::DEPTH_W-1:0]     out_depth,
	output logic                            out_full
);

	jas_pkg::state_t            state_q, state_d;
	logic [jas_pkg::REQ_W-1:0]  op_q;
	logic [jas_pkg::SNAP_W-1:0] snap_q;
	logic [jas_pkg::CNT_W-1:0]  fill_q, fill_d;
	logic                       out_valid_q;
	logic                       warm_q, full_q;
	logic [jas_pkg::DEPTH_W-1:0] depth_q;

	logic fire;
	logic is_lookup, is_touch;
	logic warm_d, full_d, push;
	logic room;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jas_pkg::ST_IDLE: begin
				if (acc) begin
					state_d = jas_pkg::ST_RES;
				end
			end
			jas_pkg::ST_RES: begin
				if (fire) begin
					state_d = jas_pkg::ST_IDLE;
				end
			end
			default: state_d = jas_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		case (state_q)
			jas_pkg::ST_IDLE: in_ready = 1'b1;
			jas_pkg::ST_RES:  fire = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				fire     = 1'b0;
			end
		endcase
	end

	// Decode the held request against the hit chain
	always_comb begin
		is_lookup = op_q inside {jas_pkg::REQ_TOUCH_ADDR, jas_pkg::REQ_TOUCH_SLOT,
		                         jas_pkg::REQ_QUERY_ADDR, jas_pkg::REQ_QUERY_SLOT};
		is_touch  = op_q inside {jas_pkg::REQ_TOUCH_ADDR, jas_pkg::REQ_TOUCH_SLOT};
		room      = (fill_q < jas_pkg::CNT_W'(jas_pkg::ENTRIES));
		warm_d    = is_lookup && hit;
		push      = is_touch && !hit && room;
		full_d    = is_touch && !hit && !room;
		fill_d    = fill_q;
		if (push) begin
			fill_d = fill_q + jas_pkg::CNT_W'(1);
		end else if ((op_q == jas_pkg::REQ_REVERT) &&
		             ((jas_pkg::CNT_W + jas_pkg::SNAP_W)'(snap_q) <=
		              (jas_pkg::CNT_W + jas_pkg::SNAP_W)'(fill_q))) begin
			fill_d = jas_pkg::CNT_W'(snap_q);
		end
	end

	assign ctl.we     = fire && push;
	assign ctl.wr_idx = fill_q[jas_pkg::IDX_W-1:0];
	assign ctl.fill   = fill_q;

	// Hold the request code and revert depth for the result cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= req_type;
			snap_q <= snapshot_id;
		end
	end

	// Advance state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jas_pkg::ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				fill_q <= fill_d;
			end
		end
	end

	// Result register: load on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			warm_q  <= warm_d;
			full_q  <= full_d;
			depth_q <= jas_pkg::DEPTH_W'(fill_d);
		end
	end

	assign out_valid = out_valid_q;
	assign out_warm  = warm_q;
	assign out_full  = full_q;
	assign out_depth = depth_q;

endmodule
`default_nettype wire

// ----- hw/rtl/journaled_access_set_unit.sv -----
// Top level: row of entry cells joined by a hit chain, driven by the sequencer.
//
//   channel | dir | payload
//   req     | in  | req_type, addr_high/mid/low, slot_w3..w0, snapshot_id
//   res     | out | was_warm, depth_now, full_res
//
// For each item, every cell compares its entry with the key as the item is taken;
// in the result state the sequencer then folds the hit chain, updates the fill count
// and loads the result register. The result register frees the request side, so
// a new item is taken while a result waits; a held result stalls only the result
// cycle of the following item. Reset clears the fill count, the sequencer and the
// result valid; entries are not cleared.
`default_nettype none
module journaled_access_set_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	jas_req_if.sink     req,
	jas_res_if.source   res
);

	logic               acc;
	logic               in_ready;
	jas_pkg::key_t      cmp_key;
	jas_pkg::key_t      key_q;
	jas_pkg::cell_ctl_t ctl;
	logic [jas_pkg::ENTRIES:0] hit_chain;

	assign req.ready = in_ready;
	assign acc       = req.valid && in_ready;

	// Build the lookup key from the request
	always_comb begin
		cmp_key.is_slot   = (req.req_type == jas_pkg::REQ_TOUCH_SLOT) ||
		                    (req.req_type == jas_pkg::REQ_QUERY_SLOT);
		cmp_key.addr_high = req.addr_high;
		cmp_key.addr_mid  = req.addr_mid;
		cmp_key.addr_low  = req.addr_low;
		cmp_key.slot_w3   = req.slot_w3;
		cmp_key.slot_w2   = req.slot_w2;
		cmp_key.slot_w1   = req.slot_w1;
		cmp_key.slot_w0   = req.slot_w0;
	end

	// Hold the key for a possible push
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= cmp_key;
		end
	end

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < jas_pkg::ENTRIES; i++) begin : g_cell
		jas_cell u_cell (
			.clk     (clk),
			.idx     (jas_pkg::IDX_W'(i)),
			.cmp_en  (acc),
			.cmp_key (cmp_key),
			.wr_key  (key_q),
			.ctl     (ctl),
			.hit_in  (hit_chain[i]),
			.hit_out (hit_chain[i+1])
		);
	end

	jas_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.req_type    (req.req_type),
		.snapshot_id (req.snapshot_id),
		.hit         (hit_chain[jas_pkg::ENTRIES]),
		.out_ready   (res.ready),
		.in_ready    (in_ready),
		.ctl         (ctl),
		.out_valid   (res.valid),
		.out_warm    (res.was_warm),
		.out_depth   (res.depth_now),
		.out_full    (res.full_res)
	);

endmodule
`default_nettype wire

// ----- dv/jas_checker.sv -----
// Checker for the journaled access set: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module jas_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	jas_req_if                        req,
	jas_res_if                        res,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen,
	output int                        warm_seen,
	output int                        full_seen,
	output logic [jas_pkg::CNT_W-1:0] fill_now
);
	import jas_pkg::*;

	typedef struct packed {
		logic               was_warm;
		logic [DEPTH_W-1:0] depth_now;
		logic               full_res;
	} access_result_t;

	key_t             warm_entries [ENTRIES];
	logic [CNT_W-1:0] fill_count;
	access_result_t   expected_results [$];

	assign fill_now = fill_count;

	// Search the live part of the stack; address and slot keys never match each other
	function automatic logic key_is_warm(input key_t k);
		for (int i = 0; i < fill_count; i++) begin
			if (warm_entries[i].is_slot == k.is_slot &&
			    warm_entries[i].addr_high == k.addr_high &&
			    warm_entries[i].addr_mid == k.addr_mid &&
			    warm_entries[i].addr_low == k.addr_low &&
			    (!k.is_slot ||
			     (warm_entries[i].slot_w3 == k.slot_w3 &&
			      warm_entries[i].slot_w2 == k.slot_w2 &&
			      warm_entries[i].slot_w1 == k.slot_w1 &&
			      warm_entries[i].slot_w0 == k.slot_w0)))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Apply one request to the predicted stack and return the result it gives
	function automatic access_result_t predict_access(input logic [REQ_W-1:0] kind,
			input key_t k, input logic [SNAP_W-1:0] snap);
		access_result_t r;
		logic           hit;
		r = '0;
		case (kind)
			REQ_TOUCH_ADDR, REQ_TOUCH_SLOT, REQ_QUERY_ADDR, REQ_QUERY_SLOT: begin
				hit = key_is_warm(k);
				r.was_warm = hit;
				if (!hit && (kind == REQ_TOUCH_ADDR || kind == REQ_TOUCH_SLOT)) begin
					if (fill_count >= ENTRIES) begin
						r.full_res = 1'b1;
					end else begin
						warm_entries[fill_count] = k;
						fill_count = fill_count + 1'b1;
					end
				end
			end
			REQ_REVERT: begin
				// a snapshot above the current depth is ignored
				if (snap <= fill_count)
					fill_count = snap;
			end
			default: begin
			end
		endcase
		r.depth_now = DEPTH_W'(fill_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_t           k;
		access_result_t got;
		access_result_t want;
		if (!arst_n) begin
			fill_count = '0;
			expected_results.delete();
			fail_count   = 0;
			results_seen = 0;
			warm_seen    = 0;
			full_seen    = 0;
		end else begin
			// compare the returned item with the oldest prediction
			if (res.valid && res.ready) begin
				got = '{res.was_warm, res.depth_now, res.full_res};
				results_seen++;
				warm_seen += got.was_warm;
				full_seen += got.full_res;
				if (expected_results.size() == 0) begin
					$error("result item with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.was_warm !== want.was_warm) begin
						$error("was_warm: expected %0d, got %0d", want.was_warm, got.was_warm);
						fail_count++;
					end
					if (got.depth_now !== want.depth_now) begin
						$error("depth_now: expected %0d, got %0d",
							want.depth_now, got.depth_now);
						fail_count++;
					end
					if (got.full_res !== want.full_res) begin
						$error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
						fail_count++;
					end
				end
			end
			// predict the result of each accepted request
			if (req.valid && req.ready) begin
				k.is_slot   = (req.req_type == REQ_TOUCH_SLOT || req.req_type == REQ_QUERY_SLOT);
				k.addr_high = req.addr_high;
				k.addr_mid  = req.addr_mid;
				k.addr_low  = req.addr_low;
				k.slot_w3   = k.is_slot ? req.slot_w3 : '0;
				k.slot_w2   = k.is_slot ? req.slot_w2 : '0;
				k.slot_w1   = k.is_slot ? req.slot_w1 : '0;
				k.slot_w0   = k.is_slot ? req.slot_w0 : '0;
				expected_results.push_back(predict_access(req.req_type, k, req.snapshot_id));
			end
		end
		pending = expected_results.size();
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: drives requests and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
	import jas_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT  = 1000;
	localparam int POOL_SIZE    = 16;
	localparam int IDLE_PCT     = 30;

	logic             clk;
	logic             arst_n;
	int               idle_pct;
	int               stalled_cycles;
	int               n_touch;
	int               n_query;
	int               n_revert;
	int               n_spare;
	int               fail_count;
	int               pending;
	int               results_seen;
	int               warm_seen;
	int               full_seen;
	logic [CNT_W-1:0] fill_now;
	key_t             addr_pool [POOL_SIZE];
	key_t             slot_pool [POOL_SIZE];

	jas_req_if req_ch ();
	jas_res_if res_ch ();

	journaled_access_set_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	jas_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.res          (res_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.warm_seen    (warm_seen),
		.full_seen    (full_seen),
		.fill_now     (fill_now)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Abort when no item moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic key_t random_key(input logic is_slot);
		key_t k;
		k = {1'b0, $urandom, rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
		k.is_slot = is_slot;
		return k;
	endfunction

	function automatic logic is_slot_kind(input logic [REQ_W-1:0] kind);
		return kind == REQ_TOUCH_SLOT || kind == REQ_QUERY_SLOT;
	endfunction

	// Build the key pools; every other entry differs from its neighbour in one bit only
	task automatic build_pools();
		logic [159:0] a;
		logic [255:0] s;
		for (int i = 0; i < POOL_SIZE; i++) begin
			addr_pool[i] = random_key(1'b0);
			if (i % 2 == 1) begin
				addr_pool[i] = addr_pool[i-1];
				a = {addr_pool[i].addr_high, addr_pool[i].addr_mid, addr_pool[i].addr_low};
				a[$urandom_range(159)] ^= 1'b1;
				{addr_pool[i].addr_high, addr_pool[i].addr_mid, addr_pool[i].addr_low} = a;
			end
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			slot_pool[i] = random_key(1'b1);
			// share addresses with the address pool
			slot_pool[i].addr_high = addr_pool[i].addr_high;
			slot_pool[i].addr_mid  = addr_pool[i].addr_mid;
			slot_pool[i].addr_low  = addr_pool[i].addr_low;
			if (i % 2 == 1) begin
				slot_pool[i] = slot_pool[i-1];
				s = {slot_pool[i].slot_w3, slot_pool[i].slot_w2,
					slot_pool[i].slot_w1, slot_pool[i].slot_w0};
				s[$urandom_range(255)] ^= 1'b1;
				{slot_pool[i].slot_w3, slot_pool[i].slot_w2,
					slot_pool[i].slot_w1, slot_pool[i].slot_w0} = s;
			end
		end
	endtask

	// Present one item, idling first at random, and hold it until it is taken
	task automatic issue(input logic [REQ_W-1:0] kind, input key_t k,
			input logic [SNAP_W-1:0] snap);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.req_type    = kind;
		req_ch.addr_high   = k.addr_high;
		req_ch.addr_mid    = k.addr_mid;
		req_ch.addr_low    = k.addr_low;
		req_ch.slot_w3     = k.slot_w3;
		req_ch.slot_w2     = k.slot_w2;
		req_ch.slot_w1     = k.slot_w1;
		req_ch.slot_w0     = k.slot_w0;
		req_ch.snapshot_id = snap;
		req_ch.valid       = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		case (kind)
			REQ_TOUCH_ADDR, REQ_TOUCH_SLOT: n_touch++;
			REQ_QUERY_ADDR, REQ_QUERY_SLOT: n_query++;
			REQ_REVERT:                     n_revert++;
			default:                        n_spare++;
		endcase
	endtask

	// Touch or query a fresh key or one from the pools; slot words on address items are noise
	task automatic issue_access(input logic [REQ_W-1:0] kind, input bit fresh);
		key_t k;
		k = random_key(is_slot_kind(kind));
		if (!fresh) begin
			if (is_slot_kind(kind)) begin
				k = slot_pool[$urandom_range(POOL_SIZE - 1)];
			end else begin
				k = addr_pool[$urandom_range(POOL_SIZE - 1)];
				k.slot_w3 = rand64();
				k.slot_w2 = rand64();
				k.slot_w1 = rand64();
				k.slot_w0 = rand64();
			end
		end
		issue(kind, k, SNAP_W'($urandom));
	endtask

	task automatic issue_revert(input bit above);
		if (above)
			issue(REQ_REVERT, random_key(1'b0), SNAP_W'($urandom_range(fill_now + 1, 127)));
		else
			issue(REQ_REVERT, random_key(1'b0), SNAP_W'($urandom_range(0, fill_now)));
	endtask

	function automatic logic [REQ_W-1:0] any_access();
		return REQ_W'($urandom_range(REQ_TOUCH_ADDR, REQ_QUERY_SLOT));
	endfunction

	function automatic logic [REQ_W-1:0] any_touch();
		return $urandom_range(1) ? REQ_TOUCH_SLOT : REQ_TOUCH_ADDR;
	endfunction

	// Warm some pool keys, fill the stack mostly with fresh keys, then go on touching and querying
	task automatic fill_to_full();
		int guard;
		repeat ($urandom_range(2, 8)) issue_access(any_touch(), 1'b0);
		guard = 0;
		while (fill_now < ENTRIES && guard < 200) begin
			if ($urandom_range(9) < 8)
				issue_access(any_touch(), $urandom_range(9) != 0);
			else
				issue_access(any_access(), 1'b0);
			guard++;
		end
		repeat ($urandom_range(4, 10)) issue_access(any_access(), $urandom_range(1) != 0);
	endtask

	// Mostly pool traffic so that hits and misses mix, with the odd checkpoint roll-back
	task automatic mixed_traffic();
		repeat ($urandom_range(20, 40)) begin
			if ($urandom_range(9) == 0)
				issue_revert(1'b0);
			else
				issue_access(any_access(), $urandom_range(3) == 0);
		end
	endtask

	task automatic noise_items();
		repeat ($urandom_range(2, 6)) begin
			case ($urandom_range(2))
				0: issue(REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
					random_key(1'b0), SNAP_W'($urandom));
				1: issue_revert(1'b1);
				default: issue_access(any_access(), 1'b1);
			endcase
		end
	endtask

	initial begin
		key_t kz;
		key_t ko;
		key_t kx;
		int   start;
		int   sel;
		arst_n             = 1'b0;
		idle_pct           = IDLE_PCT;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_TOUCH_ADDR;
		req_ch.addr_high   = '0;
		req_ch.addr_mid    = '0;
		req_ch.addr_low    = '0;
		req_ch.slot_w3     = '0;
		req_ch.slot_w2     = '0;
		req_ch.slot_w1     = '0;
		req_ch.slot_w0     = '0;
		req_ch.snapshot_id = '0;
		res_ch.ready       = 1'b0;
		build_pools();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme keys, address versus slot sets, unused codes, reverts below, at and above depth
		kz = '0;
		ko = '1;
		kx = '1;
		kx.slot_w3 = '0;
		kx.slot_w2 = '0;
		kx.slot_w1 = '0;
		kx.slot_w0 = '0;
		issue(REQ_QUERY_ADDR, kz, '0);
		issue(REQ_TOUCH_ADDR, kz, '0);
		issue(REQ_TOUCH_ADDR, {kz[416:256], {256{1'b1}}}, '1);
		issue(REQ_TOUCH_ADDR, ko, '1);
		issue(REQ_QUERY_SLOT, ko, '0);
		issue(REQ_TOUCH_SLOT, ko, '0);
		issue(REQ_TOUCH_SLOT, ko, '0);
		issue(REQ_QUERY_ADDR, ko, '0);
		issue(REQ_TOUCH_SLOT, kz, '0);
		issue(REQ_QUERY_SLOT, kx, '0);
		issue(REQ_REVERT, kz, SNAP_W'(5));
		issue(REQ_REVERT, ko, SNAP_W'(4));
		issue(REQ_REVERT, kz, SNAP_W'(2));
		issue(REQ_QUERY_SLOT, ko, '0);
		issue(REQ_QUERY_ADDR, ko, '0);
		issue(REQ_SPARE_FIRST, ko, '1);
		issue(REQ_SPARE_FIRST + 1'b1, kz, '0);
		issue(REQ_SPARE_LAST, ko, '1);
		issue(REQ_REVERT, ko, '0);
		issue(REQ_REVERT, kz, '1);
		issue(REQ_REVERT, kz, SNAP_W'(ENTRIES));

		// Random episodes; a stretch in the middle runs with no idling on either side
		start = n_touch + n_query + n_revert;
		while (n_touch + n_query + n_revert - start < RANDOM_ITEMS) begin
			sel = n_touch + n_query + n_revert - start;
			idle_pct = (sel >= 700 && sel < 1000) ? 0 : IDLE_PCT;
			sel = $urandom_range(99);
			if (sel < 25) begin
				fill_to_full();
			end else if (sel < 70) begin
				mixed_traffic();
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 3)) issue_revert($urandom_range(4) == 0);
			end else begin
				noise_items();
			end
		end
		req_ch.valid = 1'b0;

		// Drain, then wait for any stray result
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("Summary: %0d touches, %0d queries, %0d reverts, %0d unused codes sent",
			n_touch, n_query, n_revert, n_spare);
		$display("Summary: %0d results checked, %0d warm, %0d refused on a full store",
			results_seen, warm_seen, full_seen);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/jas_pkg.sv
hw/rtl/jas_req_if.sv
hw/rtl/jas_res_if.sv
hw/rtl/jas_cell.sv
hw/rtl/jas_ctrl.sv
hw/rtl/journaled_access_set_unit.sv
dv/jas_checker.sv
dv/tb_top.sv
